@@ rtl/csvx_pkg.sv @@
// csvx_pkg: shared types, register indexes and helpers for the CSV cell extractor.
// Used by csvx_front, csvx_fifo, csvx_engine and csv_cell_extractor; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csvx_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_CHAR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_END_CHAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ROW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COL   = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_byte;
      logic       byte_valid;
      logic       cell_last;
      logic       cell_found;
   } rsp_type;

   // classified byte as handed from the front to the engine
   typedef struct packed {
      logic [7:0] text_byte;
      logic       eot;
      logic       is_quote;
      logic       is_delim;
      logic       is_row_end;
   } class_type;

   typedef struct packed {
      logic [15:0] target_row;
      logic [15:0] target_col;
   } target_type;

   function automatic rsp_type rsp_content(input logic [7:0] b);
      rsp_type r;
      r.cell_byte  = b;
      r.byte_valid = 1'b1;
      r.cell_last  = 1'b0;
      r.cell_found = 1'b0;
      return r;
   endfunction

   function automatic rsp_type rsp_close(input logic found);
      rsp_type r;
      r.cell_byte  = 8'd0;
      r.byte_valid = 1'b0;
      r.cell_last  = 1'b1;
      r.cell_found = found;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/csv_cell_extractor.sv @@
// csv_cell_extractor: one text byte per transaction in, bytes of the selected cell out.
// Each result passes through the queue and then the output register before it is valid.
// Throughput: one byte per cycle while the output is taken; a byte that releases a held-back
// quote yields two results, which leave one after the other via the second slot and hold off
// the next byte until the second result has moved to the output register.
// Reset (synchronous): registers to defaults, skip-rows phase, counters cleared, queue empty.
// Depends on csvx_pkg, csvx_front, csvx_fifo and csvx_engine.
`timescale 1ns / 1ps
`default_nettype none

module csv_cell_extractor #(
   parameter int COUNT_BITS = csvx_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [csvx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [csvx_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire csvx_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output csvx_pkg::rsp_type                     rsp_data
);
   import csvx_pkg::*;

   class_type   front_class;
   class_type   queue_data;
   target_type  targets;
   logic        queue_full;
   logic        queue_not_empty;
   logic        queue_pop;

   assign req_ready = !queue_full;

   csvx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_data   (req_data),
      .class_data (front_class),
      .targets    (targets)
   );

   csvx_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .wr_data   (front_class),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .rd_data   (queue_data)
   );

   csvx_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .targets   (targets),
      .in_valid  (queue_not_empty),
      .in_data   (queue_data),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/csvx_front.sv @@
// csvx_front: configuration registers and byte classification ahead of the queue.
// Depends on csvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvx_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [csvx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csvx_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire csvx_pkg::req_type                 req_data,
   output csvx_pkg::class_type                    class_data,
   output csvx_pkg::target_type                   targets
);
   import csvx_pkg::*;

   logic [7:0]  quote_ff,   quote_in;
   logic [7:0]  delim_ff,   delim_in;
   logic [7:0]  row_end_ff, row_end_in;
   logic [15:0] trow_ff,    trow_in;
   logic [15:0] tcol_ff,    tcol_in;

   always_comb begin
      quote_in   = quote_ff;
      delim_in   = delim_ff;
      row_end_in = row_end_ff;
      trow_in    = trow_ff;
      tcol_in    = tcol_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_QUOTE_CHAR:   quote_in   = csr_wdata[7:0];
            CSR_DELIM_CHAR:   delim_in   = csr_wdata[7:0];
            CSR_ROW_END_CHAR: row_end_in = csr_wdata[7:0];
            CSR_TARGET_ROW:   trow_in    = csr_wdata;
            CSR_TARGET_COL:   tcol_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff   <= 8'd34;
         delim_ff   <= 8'd44;
         row_end_ff <= 8'd10;
         trow_ff    <= 16'd0;
         tcol_ff    <= 16'd0;
      end else begin
         quote_ff   <= quote_in;
         delim_ff   <= delim_in;
         row_end_ff <= row_end_in;
         trow_ff    <= trow_in;
         tcol_ff    <= tcol_in;
      end
   end

   always_comb begin
      class_data.text_byte  = req_data.text_byte;
      class_data.eot        = req_data.end_of_text;
      class_data.is_quote   = (req_data.text_byte == quote_ff);
      class_data.is_delim   = (req_data.text_byte == delim_ff);
      class_data.is_row_end = (req_data.text_byte == row_end_ff);
      targets.target_row    = trow_ff;
      targets.target_col    = tcol_ff;
   end

endmodule

`default_nettype wire

@@ rtl/csvx_fifo.sv @@
// csvx_fifo: short queue of classified bytes between the front and the engine.
// Depends on csvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvx_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire csvx_pkg::class_type  wr_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      not_empty,
   output csvx_pkg::class_type       rd_data
);
   import csvx_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   class_type          mem [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff,  count_in;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/csvx_engine.sv @@
// csvx_engine: row/column skipping state machine and cell copy, with output register
// and a second slot for bytes that release a held-back quote. Depends on csvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvx_engine #(
   parameter int COUNT_BITS = csvx_pkg::COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csvx_pkg::target_type   targets,
   input  wire logic                   in_valid,
   input  wire csvx_pkg::class_type    in_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output csvx_pkg::rsp_type           rsp_data
);
   import csvx_pkg::*;

   localparam int CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [2:0] {
      PH_SKIP_ROWS,
      PH_SKIP_COLS,
      PH_QSKIP_IN,
      PH_QSKIP_AFTER,
      PH_CELL,
      PH_QCOPY,
      PH_QPEND,
      PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in, ph;
   logic [COUNT_BITS-1:0]  rows_ff, rows_in;
   logic [COUNT_BITS-1:0]  cols_ff, cols_in;
   logic [7:0]             pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   logic                   extra_valid_ff, extra_valid_in;
   rsp_type                extra_ff, extra_in;

   logic                   out_free;
   logic                   rows_ge, cols_ge;
   logic                   is_end;
   logic [1:0]             n_res;
   rsp_type                r0, r1;

   assign out_free  = !out_valid_ff || rsp_ready;
   // an item is only taken when all of its results have a place to go
   assign pop       = in_valid && out_free && !extra_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign rows_ge = CmpW'(rows_ff) >= CmpW'(targets.target_row);
   assign cols_ge = CmpW'(cols_ff) >= CmpW'(targets.target_col);
   assign is_end  = in_data.eot || in_data.is_delim || in_data.is_row_end;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   always_comb begin
      ph      = phase_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      pend_in = pend_ff;
      n_res   = 2'd0;
      r0      = '0;
      r1      = '0;
      if (pop) begin
         if (ph == PH_SKIP_ROWS && rows_ge) begin
            ph = PH_SKIP_COLS;
         end
         if (ph == PH_SKIP_COLS && cols_ge) begin
            ph = PH_CELL;
         end
         unique case (ph) inside
            PH_SKIP_ROWS, PH_SKIP_COLS, PH_QSKIP_IN, PH_QSKIP_AFTER: begin
               if (in_data.eot) begin
                  ph    = PH_DONE;
                  n_res = 2'd1;
                  r0    = rsp_close(1'b0);
               end else begin
                  unique case (ph) inside
                     PH_SKIP_ROWS: begin
                        if (in_data.is_row_end) rows_in = sat_inc(rows_ff);
                     end
                     PH_SKIP_COLS: begin
                        if (in_data.is_quote) begin
                           ph = PH_QSKIP_IN;
                        end else if (in_data.is_delim) begin
                           cols_in = sat_inc(cols_ff);
                        end
                     end
                     PH_QSKIP_IN: begin
                        if (in_data.is_quote) ph = PH_QSKIP_AFTER;
                     end
                     default: begin
                        // after a closing-quote candidate
                        if (in_data.is_delim || in_data.is_row_end) begin
                           cols_in = sat_inc(cols_ff);
                           ph      = PH_SKIP_COLS;
                        end else if (!in_data.is_quote) begin
                           ph = PH_QSKIP_IN;
                        end
                     end
                  endcase
               end
            end
            PH_CELL: begin
               if (is_end) begin
                  ph    = PH_DONE;
                  n_res = 2'd1;
                  r0    = rsp_close(1'b1);
               end else if (in_data.is_quote) begin
                  ph = PH_QCOPY;
               end else begin
                  n_res = 2'd1;
                  r0    = rsp_content(in_data.text_byte);
               end
            end
            PH_QCOPY: begin
               if (in_data.eot) begin
                  ph    = PH_DONE;
                  n_res = 2'd1;
                  r0    = rsp_close(1'b1);
               end else if (in_data.is_quote) begin
                  pend_in = in_data.text_byte;
                  ph      = PH_QPEND;
               end else begin
                  n_res = 2'd1;
                  r0    = rsp_content(in_data.text_byte);
               end
            end
            PH_QPEND: begin
               if (is_end) begin
                  ph    = PH_DONE;
                  n_res = 2'd1;
                  r0    = rsp_close(1'b1);
               end else begin
                  r0 = rsp_content(pend_ff);
                  if (in_data.is_quote) begin
                     n_res   = 2'd1;
                     pend_in = in_data.text_byte;
                  end else begin
                     n_res = 2'd2;
                     r1    = rsp_content(in_data.text_byte);
                     ph    = PH_QCOPY;
                  end
               end
            end
            default: ;  // done: transactions are drained without results
         endcase
      end
      phase_in = ph;
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      extra_valid_in = extra_valid_ff;
      extra_in       = extra_ff;
      if (out_free) begin
         if (extra_valid_ff) begin
            out_valid_in   = 1'b1;
            out_in         = extra_ff;
            extra_valid_in = 1'b0;
         end else if (n_res != 2'd0) begin
            out_valid_in   = 1'b1;
            out_in         = r0;
            extra_valid_in = (n_res == 2'd2);
            extra_in       = r1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SKIP_ROWS;
         rows_ff        <= '0;
         cols_ff        <= '0;
         pend_ff        <= 8'd0;
         out_valid_ff   <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         rows_ff        <= rows_in;
         cols_ff        <= cols_in;
         pend_ff        <= pend_in;
         out_valid_ff   <= out_valid_in;
         extra_valid_ff <= extra_valid_in;
      end
      out_ff   <= out_in;
      extra_ff <= extra_in;
   end

endmodule

`default_nettype wire
